[rtl/rtc_pkg.sv]
`timescale 1ns / 1ps
package rtc_pkg;

    localparam int DEF_COORD_WIDTH   = 32;
    localparam int DEF_MAX_TRIANGLES = 65536;

    localparam int WORD_W    = 32;
    localparam int IDX_W     = 16;
    localparam int DIFF_W    = 33;
    localparam int CROSS_W   = 2 * DIFF_W + 1;
    localparam int ACC_W     = 104;
    localparam int DET_EPS_LOG2 = 28;
    localparam int CFG_IDX_W = 4;
    localparam int IN_DATA_W  = 288;
    localparam int OUT_DATA_W = 112;

    localparam logic [WORD_W-1:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] Q_MIN = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FAR      = 4'd7;

    typedef struct packed {
        logic [2:0][DIFF_W-1:0] e1;
        logic [2:0][DIFF_W-1:0] e2;
        logic [2:0][DIFF_W-1:0] tv;
        logic [2:0][DIFF_W-1:0] d;
        logic                   last;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  hit_triangle;
        logic [WORD_W-1:0] bary_third;
        logic [WORD_W-1:0] bary_second;
        logic [WORD_W-1:0] hit_depth;
    } result_t;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] num;
        logic [ACC_W-1:0]        den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] q;
    } div_rsp_t;

endpackage

[rtl/rtc_fifo.sv]
`timescale 1ns / 1ps
module rtc_fifo
    import rtc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             rvalid,
    output logic [WIDTH-1:0] rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    assign full   = (cnt_reg == CW'(DEPTH));
    assign rvalid = (cnt_reg != '0);
    assign rdata  = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

[rtl/rtc_front.sv]
`timescale 1ns / 1ps
module rtc_front
    import rtc_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
)
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic [WORD_W-1:0]    origin_x,
    input  logic [WORD_W-1:0]    origin_y,
    input  logic [WORD_W-1:0]    origin_z,
    input  logic [WORD_W-1:0]    dir_x,
    input  logic [WORD_W-1:0]    dir_y,
    input  logic [WORD_W-1:0]    dir_z,
    input  logic                 full,
    output logic                 push,
    output item_t                item
);

    localparam int CB = (COORD_WIDTH < WORD_W) ? COORD_WIDTH : WORD_W;

    logic [WORD_W-1:0] w_a, w_b, w_c, w_o, w_d;
    logic [WORD_W-1:0] org [3];
    logic [WORD_W-1:0] dir [3];

    assign org[0] = origin_x;
    assign org[1] = origin_y;
    assign org[2] = origin_z;
    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    always_comb
    begin
        w_a = '0;
        w_b = '0;
        w_c = '0;
        w_o = '0;
        w_d = '0;
        item.last = s_tlast;
        for (int i = 0; i < 3; i++)
        begin
            w_a = s_tdata[WORD_W*i +: WORD_W];
            w_b = s_tdata[WORD_W*(i+3) +: WORD_W];
            w_c = s_tdata[WORD_W*(i+6) +: WORD_W];
            w_o = org[i];
            w_d = dir[i];
            item.e1[i] = DIFF_W'(signed'(w_b[CB-1:0])) - DIFF_W'(signed'(w_a[CB-1:0]));
            item.e2[i] = DIFF_W'(signed'(w_c[CB-1:0])) - DIFF_W'(signed'(w_a[CB-1:0]));
            item.tv[i] = DIFF_W'(signed'(w_o[CB-1:0])) - DIFF_W'(signed'(w_a[CB-1:0]));
            item.d[i]  = DIFF_W'(signed'(w_d[CB-1:0]));
        end
    end

endmodule

[rtl/rtc_div.sv]
`timescale 1ns / 1ps
module rtc_div
    import rtc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int RW  = ACC_W + 16;
    localparam int DSW = ACC_W + 31;

    logic [RW-1:0]     rem_reg, rem_next;
    logic [DSW-1:0]    dsh_reg, dsh_next;
    logic [30:0]       q_reg, q_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next, neg_reg, neg_next, done_reg, done_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic [ACC_W-1:0]  mag;
    logic              ge;
    logic [30:0]       qf;

    assign rsp.done = done_reg;
    assign rsp.q    = res_reg;

    always_comb
    begin
        mag       = req.num[ACC_W-1] ? ACC_W'(-req.num) : ACC_W'(req.num);
        ge        = DSW'(rem_reg) >= dsh_reg;
        qf        = {q_reg[29:0], ge};
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                rem_next  = RW'(mag) << 16;
                dsh_next  = DSW'(req.den) << 31;
                neg_next  = req.num[ACC_W-1];
                cnt_next  = '0;
                busy_next = 1'b1;
            end
        end
        else if (cnt_reg == '0)
        begin
            if (ge)
            begin
                res_next  = neg_reg ? Q_MIN : Q_MAX;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
            end
        end
        else
        begin
            if (ge)
            begin
                rem_next = rem_reg - RW'(dsh_reg);
            end
            q_next   = qf;
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 5'd31)
            begin
                res_next  = neg_reg ? WORD_W'(-{1'b0, qf}) : {1'b0, qf};
                done_next = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

endmodule

[rtl/rtc_back.sv]
`timescale 1ns / 1ps
module rtc_back
    import rtc_pkg::*;
#(
    parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  item_t             item_in,
    output logic              pop,
    input  logic [WORD_W-1:0] near_limit,
    input  logic [WORD_W-1:0] far_limit,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              hit_out,
    output result_t           res_out
);

    localparam int CNT_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_SIGN = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_DT   = 4'd5;
    localparam logic [3:0] S_DU   = 4'd6;
    localparam logic [3:0] S_DV   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    localparam logic [1:0] XK_E1 = 2'd0;
    localparam logic [1:0] XK_E2 = 2'd1;
    localparam logic [1:0] XK_P  = 2'd2;
    localparam logic [1:0] XK_Q  = 2'd3;
    localparam logic [1:0] YK_D  = 2'd0;
    localparam logic [1:0] YK_E1 = 2'd1;
    localparam logic [1:0] YK_E2 = 2'd2;
    localparam logic [1:0] YK_TV = 2'd3;
    localparam logic [2:0] DK_P   = 3'd0;
    localparam logic [2:0] DK_Q   = 3'd1;
    localparam logic [2:0] DK_DET = 3'd2;
    localparam logic [2:0] DK_NU  = 3'd3;
    localparam logic [2:0] DK_NV  = 3'd4;
    localparam logic [2:0] DK_NT  = 3'd5;
    localparam logic [4:0] LAST_OP = 5'd23;

    typedef struct packed {
        logic [1:0] xk;
        logic [1:0] xi;
        logic [1:0] yk;
        logic [1:0] yi;
        logic       neg;
        logic       first;
        logic       store;
        logic [2:0] dk;
        logic [1:0] di;
    } op_t;

    function automatic op_t op_dec(input logic [4:0] idx);
        op_t        o;
        logic [2:0] c;
        logic [4:0] d;
        logic [1:0] g, i, j, k;
        logic       sec, isq;
        o   = '0;
        c   = idx[3:1];
        sec = idx[0];
        d   = idx - 5'd12;
        if (idx < 5'd12)
        begin
            isq = (c >= 3'd3);
            i   = isq ? 2'(c - 3'd3) : c[1:0];
            j   = (i == 2'd2) ? 2'd0 : i + 2'd1;
            k   = (i == 2'd0) ? 2'd2 : i - 2'd1;
            o.xk    = isq ? XK_E1 : XK_E2;
            o.yk    = isq ? YK_TV : YK_D;
            o.xi    = sec ? j : k;
            o.yi    = sec ? k : j;
            o.neg   = sec;
            o.first = !sec;
            o.store = sec;
            o.dk    = isq ? DK_Q : DK_P;
            o.di    = i;
        end
        else
        begin
            g = (d < 5'd3) ? 2'd0 : (d < 5'd6) ? 2'd1 : (d < 5'd9) ? 2'd2 : 2'd3;
            case (g)
                2'd0:    i = d[1:0];
                2'd1:    i = 2'(d - 5'd3);
                2'd2:    i = 2'(d - 5'd6);
                default: i = 2'(d - 5'd9);
            endcase
            case (g)
                2'd0:
                begin
                    o.xk = XK_P;
                    o.yk = YK_E1;
                    o.dk = DK_DET;
                end
                2'd1:
                begin
                    o.xk = XK_P;
                    o.yk = YK_TV;
                    o.dk = DK_NU;
                end
                2'd2:
                begin
                    o.xk = XK_Q;
                    o.yk = YK_D;
                    o.dk = DK_NV;
                end
                default:
                begin
                    o.xk = XK_Q;
                    o.yk = YK_E2;
                    o.dk = DK_NT;
                end
            endcase
            o.xi    = i;
            o.yi    = i;
            o.first = (i == 2'd0);
            o.store = (i == 2'd2);
            o.di    = i;
        end
        return o;
    endfunction

    logic [3:0]                state_reg, state_next;
    logic [4:0]                op_reg, op_next;
    logic [5:0]                bcnt_reg, bcnt_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next, xs_reg, xs_next;
    logic [DIFF_W-1:0]         ys_reg, ys_next;
    logic signed [CROSS_W-1:0] p_reg [3];
    logic signed [CROSS_W-1:0] p_next [3];
    logic signed [CROSS_W-1:0] q_reg [3];
    logic signed [CROSS_W-1:0] q_next [3];
    logic signed [ACC_W-1:0]   det_reg, det_next, nu_reg, nu_next;
    logic signed [ACC_W-1:0]   nv_reg, nv_next, nt_reg, nt_next;
    item_t                     item_reg, item_next;
    logic [WORD_W-1:0]         t_reg, t_next, u_reg, u_next, v_reg, v_next;
    logic                      upd_reg, upd_next;
    logic [WORD_W-1:0]         closest_reg, closest_next, bu_reg, bu_next, bv_reg, bv_next;
    logic                      any_reg, any_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next, bi_reg, bi_next;
    logic                      out_valid_reg, out_valid_next, hit_reg, hit_next;
    result_t                   out_reg, out_next;
    div_req_t                  dreq;
    div_rsp_t                  drsp;

    op_t                       op;
    logic signed [ACC_W-1:0]   xop, term;
    logic [DIFF_W-1:0]         yop;
    logic                      sub, small_det, go, any_new;
    logic signed [ACC_W:0]     sum_uv;
    logic [WORD_W-1:0]         depth_new;

    rtc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign m_tvalid = out_valid_reg;
    assign hit_out  = hit_reg;
    assign res_out  = out_reg;

    always_comb
    begin
        op = op_dec(op_reg);
        case (op.xk)
            XK_E1:   xop = ACC_W'($signed(item_reg.e1[op.xi]));
            XK_E2:   xop = ACC_W'($signed(item_reg.e2[op.xi]));
            XK_P:    xop = ACC_W'(p_reg[op.xi]);
            default: xop = ACC_W'(q_reg[op.xi]);
        endcase
        case (op.yk)
            YK_D:    yop = item_reg.d[op.yi];
            YK_E1:   yop = item_reg.e1[op.yi];
            YK_E2:   yop = item_reg.e2[op.yi];
            default: yop = item_reg.tv[op.yi];
        endcase
        term      = ys_reg[0] ? xs_reg : '0;
        sub       = op.neg ^ (bcnt_reg == 6'd32);
        small_det = (det_reg[ACC_W-1:DET_EPS_LOG2] == '0);
        sum_uv    = (ACC_W+1)'(nu_reg) + (ACC_W+1)'(nv_reg);
        go        = !item_reg.last || !out_valid_reg || m_tready;
        any_new   = any_reg || upd_reg;
        depth_new = upd_reg ? t_reg : closest_reg;

        state_next   = state_reg;
        op_next      = op_reg;
        bcnt_next    = bcnt_reg;
        acc_next     = acc_reg;
        xs_next      = xs_reg;
        ys_next      = ys_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        det_next     = det_reg;
        nu_next      = nu_reg;
        nv_next      = nv_reg;
        nt_next      = nt_reg;
        item_next    = item_reg;
        t_next       = t_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        upd_next     = upd_reg;
        closest_next = closest_reg;
        bu_next      = bu_reg;
        bv_next      = bv_reg;
        bi_next      = bi_reg;
        any_next     = any_reg;
        cnt_next     = cnt_reg;
        hit_next     = hit_reg;
        out_next     = out_reg;
        pop          = 1'b0;
        dreq.start   = 1'b0;
        dreq.num     = nt_reg;
        dreq.den     = ACC_W'(det_reg);
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    pop        = 1'b1;
                    item_next  = item_in;
                    op_next    = '0;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                xs_next    = xop;
                ys_next    = yop;
                bcnt_next  = '0;
                acc_next   = op.first ? '0 : acc_reg;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                acc_next  = sub ? acc_reg - term : acc_reg + term;
                xs_next   = xs_reg <<< 1;
                ys_next   = ys_reg >> 1;
                bcnt_next = bcnt_reg + 1'b1;
                if (bcnt_reg == 6'd32)
                begin
                    if (op.store)
                    begin
                        case (op.dk)
                            DK_P:    p_next[op.di] = CROSS_W'(acc_next);
                            DK_Q:    q_next[op.di] = CROSS_W'(acc_next);
                            DK_DET:  det_next = acc_next;
                            DK_NU:   nu_next = acc_next;
                            DK_NV:   nv_next = acc_next;
                            default: nt_next = acc_next;
                        endcase
                    end
                    if (op_reg == LAST_OP)
                    begin
                        state_next = S_SIGN;
                    end
                    else
                    begin
                        op_next    = op_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            S_SIGN:
            begin
                if (det_reg[ACC_W-1])
                begin
                    det_next = -det_reg;
                    nu_next  = -nu_reg;
                    nv_next  = -nv_reg;
                    nt_next  = -nt_reg;
                end
                state_next = S_CHK;
            end
            S_CHK:
            begin
                upd_next = 1'b0;
                if (small_det || nu_reg[ACC_W-1] || nv_reg[ACC_W-1] ||
                    (sum_uv > (ACC_W+1)'(det_reg)))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    dreq.start = 1'b1;
                    dreq.num   = nt_reg;
                    state_next = S_DT;
                end
            end
            S_DT:
            begin
                if (drsp.done)
                begin
                    if ($signed(drsp.q) >= $signed(near_limit) &&
                        $signed(drsp.q) <= $signed(far_limit) &&
                        (!any_reg || $signed(drsp.q) <= $signed(closest_reg)))
                    begin
                        t_next     = drsp.q;
                        dreq.start = 1'b1;
                        dreq.num   = nu_reg;
                        state_next = S_DU;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_DU:
            begin
                if (drsp.done)
                begin
                    u_next     = drsp.q;
                    dreq.start = 1'b1;
                    dreq.num   = nv_reg;
                    state_next = S_DV;
                end
            end
            S_DV:
            begin
                if (drsp.done)
                begin
                    v_next     = drsp.q;
                    upd_next   = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (go)
                begin
                    if (upd_reg)
                    begin
                        closest_next = t_reg;
                        bu_next      = u_reg;
                        bv_next      = v_reg;
                        bi_next      = cnt_reg;
                        any_next     = 1'b1;
                    end
                    cnt_next = (cnt_reg == CNT_W'(MAX_TRIANGLES - 1)) ? '0 : cnt_reg + 1'b1;
                    if (item_reg.last)
                    begin
                        out_valid_next           = 1'b1;
                        hit_next                 = any_new;
                        out_next.hit_depth       = any_new ? depth_new : far_limit;
                        out_next.bary_second     = !any_new ? '0 : upd_reg ? u_reg : bu_reg;
                        out_next.bary_third      = !any_new ? '0 : upd_reg ? v_reg : bv_reg;
                        out_next.hit_triangle    = !any_new ? '0 :
                                                   IDX_W'(upd_reg ? cnt_reg : bi_reg);
                        any_next = 1'b0;
                        cnt_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            bcnt_reg      <= '0;
            any_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            upd_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            bcnt_reg      <= bcnt_next;
            any_reg       <= any_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            upd_reg       <= upd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        xs_reg      <= xs_next;
        ys_reg      <= ys_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        det_reg     <= det_next;
        nu_reg      <= nu_next;
        nv_reg      <= nv_next;
        nt_reg      <= nt_next;
        item_reg    <= item_next;
        t_reg       <= t_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        closest_reg <= closest_next;
        bu_reg      <= bu_next;
        bv_reg      <= bv_next;
        bi_reg      <= bi_next;
        hit_reg     <= hit_next;
        out_reg     <= out_next;
    end

endmodule

[rtl/ray_triangle_closest_hit.sv]
`timescale 1ns / 1ps
// Each triangle goes through 24 serial 33-bit multiply passes on the shared serial
// multiplier, then up to three divides.
// The engine works on one triangle at a time and takes the next only once it is done.
// A two-word queue decouples input acceptance from the compute engine.
// Reset (asynchronous, active low) clears control state and loads ray registers
// with their default values; no clearing pass.
module ray_triangle_closest_hit
    import rtc_pkg::*;
#(
    parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
    parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
    // vertex_c_x, vertex_c_y, vertex_c_z
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hit_depth, bary_second, bary_third, hit_triangle
    output logic [OUT_DATA_W-1:0] m_tdata,
    // hit_found
    output logic                  m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data
);

    logic [WORD_W-1:0] ox_reg, oy_reg, oz_reg, dx_reg, dy_reg, dz_reg, near_reg, far_reg;
    logic              push, full, pop, q_valid;
    item_t             f_item, q_item;
    result_t           res;

    assign cfg_ready = 1'b1;
    assign m_tdata   = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg   <= '0;
            oy_reg   <= '0;
            oz_reg   <= '0;
            dx_reg   <= '0;
            dy_reg   <= '0;
            dz_reg   <= 32'h0001_0000;
            near_reg <= '0;
            far_reg  <= Q_MAX;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ORIGIN_X: ox_reg   <= cfg_data;
                REG_ORIGIN_Y: oy_reg   <= cfg_data;
                REG_ORIGIN_Z: oz_reg   <= cfg_data;
                REG_DIR_X:    dx_reg   <= cfg_data;
                REG_DIR_Y:    dy_reg   <= cfg_data;
                REG_DIR_Z:    dz_reg   <= cfg_data;
                REG_NEAR:     near_reg <= cfg_data;
                REG_FAR:      far_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    rtc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .origin_x (ox_reg),
        .origin_y (oy_reg),
        .origin_z (oz_reg),
        .dir_x    (dx_reg),
        .dir_y    (dy_reg),
        .dir_z    (dz_reg),
        .full     (full),
        .push     (push),
        .item     (f_item)
    );

    rtc_fifo #(.WIDTH($bits(item_t)), .DEPTH(2)) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (f_item),
        .full   (full),
        .pop    (pop),
        .rvalid (q_valid),
        .rdata  (q_item)
    );

    rtc_back #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_in    (q_item),
        .pop        (pop),
        .near_limit (near_reg),
        .far_limit  (far_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .hit_out    (m_tuser),
        .res_out    (res)
    );

endmodule

[rtl/rtc_checker.sv]
`timescale 1ns / 1ps
module rtc_checker
    import rtc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[OUT_DATA_W-1:32] == '0)
        else $error("miss word carries barycentrics or index");

    a_bary_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tdata[63] && !m_tdata[95])
        else $error("negative barycentric on hit");

endmodule

bind ray_triangle_closest_hit rtc_checker u_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[bench/tb_ray_triangle_closest_hit.sv]
`timescale 1ns / 1ps
module tb_ray_triangle_closest_hit;
    import rtc_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int NUM_REGS = 8;
    localparam int DRAIN_CYCLES = 1200;
    localparam longint CYCLE_LIMIT = 8000000;
    localparam logic signed [31:0] ONE = 32'sd65536;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] depth;
        logic [31:0] bu;
        logic [31:0] bv;
        logic [15:0] idx;
    } hit_rec_t;

    typedef struct {
        logic [31:0] v[9];
        bit          last;
        bit          typed;
        hit_rec_t    r;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0] cfg_data = '0;

    logic signed [31:0] ray_reg[NUM_REGS];
    logic signed [31:0] closest_depth;
    logic any_hit;
    logic signed [31:0] best_bu, best_bv;
    logic [15:0] best_idx, tri_count;

    hit_rec_t expected_hits[$];
    int errors = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    longint cycles = 0;

    ray_triangle_closest_hit DUT (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        hit_rec_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_hits.size() == 0)
            begin
                $error("unexpected result word %h", m_tdata);
                errors++;
            end
            else
            begin
                e = expected_hits.pop_front();
                if (m_tuser !== e.hit)
                begin
                    $error("hit_found expected %0d got %0d", e.hit, m_tuser);
                    errors++;
                end
                if (m_tdata[31:0] !== e.depth)
                begin
                    $error("hit_depth expected %h got %h", e.depth, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== e.bu)
                begin
                    $error("bary_second expected %h got %h", e.bu, m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[95:64] !== e.bv)
                begin
                    $error("bary_third expected %h got %h", e.bv, m_tdata[95:64]);
                    errors++;
                end
                if (m_tdata[111:96] !== e.idx)
                begin
                    $error("hit_triangle expected %h got %h", e.idx, m_tdata[111:96]);
                    errors++;
                end
            end
        end
    end

    function automatic void clear_search();
        closest_depth = ray_reg[REG_FAR];
        any_hit = 1'b0;
        best_bu = '0;
        best_bv = '0;
        best_idx = '0;
        tri_count = '0;
    endfunction

    function automatic logic signed [31:0] q16_quot(wide_t num, wide_t den);
        wide_t q;
        q = (num * 65536) / den;
        if (q > 128'sd2147483647)
            return Q_MAX;
        if (q < -128'sd2147483648)
            return Q_MIN;
        return q[31:0];
    endfunction

    function automatic void cross3(input wide_t u[3], input wide_t v[3], output wide_t r[3]);
        for (int i = 0; i < 3; i++)
            r[i] = u[(i + 1) % 3] * v[(i + 2) % 3] - u[(i + 2) % 3] * v[(i + 1) % 3];
    endfunction

    function automatic wide_t dot(input wide_t u[3], input wide_t w[3]);
        return u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
    endfunction

    // advance the search by one triangle; return 1 with the result on the last one
    function automatic bit predict_triangle(input logic [31:0] v[9], input bit last,
                                            output hit_rec_t r);
        wide_t a[3], e1[3], e2[3], tv[3], d[3], p[3], q[3];
        wide_t det, nu, nv, nt;
        logic signed [31:0] t;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = $signed(v[i]);
            e1[i] = $signed(v[3 + i]) - a[i];
            e2[i] = $signed(v[6 + i]) - a[i];
            tv[i] = ray_reg[i] - a[i];
            d[i] = ray_reg[3 + i];
        end
        cross3(d, e2, p);
        cross3(tv, e1, q);
        det = dot(e1, p);
        nu = dot(tv, p);
        nv = dot(d, q);
        nt = dot(e2, q);
        if (det < 0)
        begin
            det = -det;
            nu = -nu;
            nv = -nv;
            nt = -nt;
        end
        if (det >= (128'sd1 <<< DET_EPS_LOG2) && nu >= 0 && nv >= 0 && nu + nv <= det)
        begin
            t = q16_quot(nt, det);
            if (t >= ray_reg[REG_NEAR] && t <= ray_reg[REG_FAR] &&
                (!any_hit || t <= closest_depth))
            begin
                closest_depth = t;
                any_hit = 1'b1;
                best_bu = q16_quot(nu, det);
                best_bv = q16_quot(nv, det);
                best_idx = tri_count;
            end
        end
        tri_count = tri_count + 16'd1;
        if (!last)
            return 0;
        r.hit = any_hit;
        r.depth = any_hit ? closest_depth : ray_reg[REG_FAR];
        r.bu = best_bu;
        r.bv = best_bv;
        r.idx = best_idx;
        clear_search();
        return 1;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx < NUM_REGS)
        begin
            ray_reg[idx] = val;
            if (idx == REG_FAR && !any_hit)
                closest_depth = val;
        end
        @(posedge clk);
    endtask

    task automatic send_triangle(input logic [31:0] v[9], input bit last,
                                 input bit typed, input hit_rec_t typed_r);
        logic [IN_DATA_W-1:0] data;
        hit_rec_t r;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
        for (int i = 0; i < 9; i++)
            data[i * 32 +: 32] = v[i];
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (predict_triangle(v, last, r))
            expected_hits = {expected_hits, (typed ? typed_r : r)};
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic random_ray();
        write_reg(REG_ORIGIN_X, $signed($urandom_range(0, 1 << 21)) - (1 << 20));
        write_reg(REG_ORIGIN_Y, $signed($urandom_range(0, 1 << 21)) - (1 << 20));
        write_reg(REG_ORIGIN_Z, $signed($urandom_range(0, 1 << 21)) - (1 << 20));
        write_reg(REG_DIR_X, $signed($urandom_range(0, 1 << 15)) - (1 << 14));
        write_reg(REG_DIR_Y, $signed($urandom_range(0, 1 << 15)) - (1 << 14));
        write_reg(REG_DIR_Z, ($urandom_range(0, 1) ? 1 : -1) *
                             $signed($urandom_range(1 << 15, 1 << 17)));
        write_reg(REG_NEAR, $signed($urandom_range(0, 3 << 16)) - (1 << 17));
        write_reg(REG_FAR, $urandom_range(0, 3) == 0 ? Q_MAX :
                           32'($urandom_range(1 << 17, 8 << 16)));
        write_reg(4'(NUM_REGS + $urandom_range(0, 7)), $urandom);
    endtask

    function automatic void aimed_triangle(output logic [31:0] v[9]);
        logic signed [31:0] k, c;
        k = $signed($urandom_range(0, 7)) - 1;
        for (int i = 0; i < 3; i++)
        begin
            c = ray_reg[i] + ray_reg[3 + i] * k;
            for (int j = 0; j < 3; j++)
                v[3 * j + i] = c + (i == 2 ? $signed($urandom_range(0, 1 << 13)) - (1 << 12)
                                           : $signed($urandom_range(0, 1 << 19)) - (1 << 18));
        end
    endfunction

    task automatic random_meshes(input int count);
        logic [31:0] v[9];
        int kind, len, n;
        hit_rec_t none;
        none = '0;
        n = 0;
        while (n < count)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 75)
                    aimed_triangle(v);
                else if (kind < 90)
                begin
                    foreach (v[j])
                        v[j] = $urandom;
                end
                else
                begin
                    aimed_triangle(v);
                    for (int j = 0; j < 3; j++)
                        v[3 + j] = v[j] + $signed($urandom_range(0, 2)) - 1;
                end
                send_triangle(v, (i == len - 1) || ($urandom_range(0, 49) == 0), 0, none);
                n++;
            end
        end
    endtask

    function automatic dir_row_t flat_row(input logic signed [31:0] z, input bit last);
        dir_row_t r;
        r.v = '{-ONE, -ONE, z, 3 * ONE, -ONE, z, -ONE, 3 * ONE, z};
        r.last = last;
        r.typed = 0;
        r.r = '0;
        return r;
    endfunction

    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        hit_rec_t hit_one;

        for (int i = 0; i < NUM_REGS; i++)
            ray_reg[i] = '0;
        ray_reg[REG_DIR_Z] = ONE;
        ray_reg[REG_FAR] = Q_MAX;
        clear_search();
        hit_one = '{1'b1, ONE, 32'd16384, 32'd16384, 16'd0};

        row = flat_row(ONE, 1);
        row.typed = 1;
        row.r = hit_one;
        rows = {rows, row};
        row.v = '{default: '0};
        row.r = '{1'b0, Q_MAX, 32'd0, 32'd0, 16'd0};
        rows = {rows, row};
        row = flat_row(-ONE, 1);
        row.typed = 1;
        row.r = '{1'b0, Q_MAX, 32'd0, 32'd0, 16'd0};
        rows = {rows, row};
        row = flat_row(ONE, 0);
        row.v = '{Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN};
        rows = {rows, row};
        row.v = '{'1, '1, '1, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN};
        rows = {rows, row};
        row = flat_row(2 * ONE, 0);
        row.v[0] = ONE;
        row.v[3] = 4 * ONE;
        rows = {rows, row};
        rows = {rows, flat_row(2 * ONE, 0)};
        rows = {rows, flat_row(ONE, 1)};
        row = flat_row(ONE, 0);
        rows = {rows, row};
        row.last = 1;
        row.typed = 1;
        row.r = hit_one;
        row.r.idx = 16'd1;
        rows = {rows, row};
        row = flat_row(0, 1);
        rows = {rows, row};
        row = flat_row(Q_MAX, 1);
        row.v[2] = ONE;
        rows = {rows, row};

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_triangle(rows[i].v, rows[i].last, rows[i].typed, rows[i].r);
        settle();

        write_reg(REG_ORIGIN_X, Q_MIN);
        write_reg(REG_ORIGIN_Y, Q_MAX);
        write_reg(REG_ORIGIN_Z, Q_MIN);
        write_reg(REG_DIR_X, Q_MAX);
        write_reg(REG_DIR_Y, Q_MIN);
        write_reg(REG_DIR_Z, Q_MAX);
        write_reg(REG_NEAR, Q_MIN);
        write_reg(REG_FAR, Q_MAX);
        write_reg(4'(NUM_REGS), '1);
        random_meshes(20);
        settle();

        random_ray();
        write_reg(REG_NEAR, Q_MAX);
        write_reg(REG_FAR, Q_MIN);
        random_meshes(20);
        settle();

        for (int phase = 0; phase < 4; phase++)
        begin
            gap_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 49 : 9) : 0;
            stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 49 : 9) : 0;
            random_ray();
            random_meshes(170);
            settle();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
rtl/rtc_pkg.sv
rtl/rtc_fifo.sv
rtl/rtc_front.sv
rtl/rtc_div.sv
rtl/rtc_back.sv
rtl/ray_triangle_closest_hit.sv
rtl/rtc_checker.sv
bench/tb_ray_triangle_closest_hit.sv
